// ----- sv/assert_macros.svh -----
// Concurrent check helpers, sampled on clk, idle while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/i2cbm_pkg.sv -----
package i2cbm_pkg;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_SEND  = 3'd2,
		CMD_WACK  = 3'd3,
		CMD_RECV  = 3'd4,
		CMD_SACK  = 3'd5,
		CMD_STOP  = 3'd6
	} cmd_t;

	localparam logic [9:0] ACK_TIMEOUT_RST = 10'd1000;
	localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       ok_flag;
		logic       done_res;
		logic       busy_res;
		logic       sda_level;
		logic       scl_level;
	} res_t;

endpackage

// ----- sv/i2cbm_core.sv -----
module i2cbm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [2:0]        cmd,
	input  logic [7:0]        tx_byte,
	input  logic              ack_level,
	input  logic              sda_in,
	input  logic [9:0]        ack_timeout,
	output i2cbm_pkg::res_t   res
);

	i2cbm_pkg::cmd_t act_q, act_n;
	logic [2:0] ph_q, ph_n;
	logic [7:0] sh_q, sh_n;
	logic [3:0] bits_q, bits_n;
	logic [9:0] poll_q, poll_n;
	logic       scl_q, scl_n, sda_q, sda_n;
	logic [7:0] rx_q, rx_n;
	logic       done, ok, cmd_new;

	assign cmd_new = (cmd >= 3'(i2cbm_pkg::CMD_START)) && (cmd <= 3'(i2cbm_pkg::CMD_STOP));

	always_comb begin
		act_n  = act_q;
		ph_n   = ph_q;
		sh_n   = sh_q;
		bits_n = bits_q;
		poll_n = poll_q;
		scl_n  = scl_q;
		sda_n  = sda_q;
		rx_n   = rx_q;
		done   = 1'b0;
		ok     = 1'b0;
		if (act_q == i2cbm_pkg::CMD_IDLE && cmd_new) begin
			act_n  = i2cbm_pkg::cmd_t'(cmd);
			ph_n   = 3'd0;
			bits_n = 4'd0;
			poll_n = 10'd0;
			if (cmd == 3'(i2cbm_pkg::CMD_SEND))
				sh_n = tx_byte;
			else if (cmd == 3'(i2cbm_pkg::CMD_SACK))
				sh_n = {7'd0, ack_level};
			else
				sh_n = 8'd0;
		end
		unique case (act_n)
			i2cbm_pkg::CMD_START: begin
				unique case (ph_n)
					3'd0: begin
						sda_n = 1'b1;
						ph_n  = 3'd1;
					end
					3'd1: begin
						scl_n = 1'b1;
						if (!sda_in) begin
							done = 1'b1;
						end else begin
							ph_n = 3'd2;
						end
					end
					3'd2: begin
						sda_n = 1'b0;
						if (sda_in) begin
							done = 1'b1;
						end else begin
							ph_n = 3'd3;
						end
					end
					default: begin
						scl_n = 1'b0;
						done  = 1'b1;
						ok    = 1'b1;
					end
				endcase
			end
			i2cbm_pkg::CMD_SEND: begin
				unique case (ph_n)
					3'd0: begin
						scl_n = 1'b0;
						ph_n  = 3'd1;
					end
					3'd1: begin
						sda_n = sh_n[7];
						ph_n  = 3'd2;
					end
					3'd2: begin
						scl_n = 1'b1;
						ph_n  = 3'd3;
					end
					default: begin
						scl_n  = 1'b0;
						sh_n   = {sh_n[6:0], 1'b0};
						bits_n = bits_n + 4'd1;
						if (bits_n >= i2cbm_pkg::BITS_PER_BYTE) begin
							done = 1'b1;
						end else begin
							ph_n = 3'd1;
						end
					end
				endcase
			end
			i2cbm_pkg::CMD_WACK: begin
				unique case (ph_n)
					3'd0: begin
						sda_n = 1'b1;
						ph_n  = 3'd1;
					end
					3'd1, 3'd2: begin
						if (ph_n == 3'd1)
							scl_n = 1'b1;
						if (!sda_in) begin
							ph_n = 3'd3;
						end else begin
							poll_n = poll_n + 10'd1;
							if (poll_n >= ack_timeout || poll_n == 10'd0)
								ph_n = 3'd4;
							else
								ph_n = 3'd2;
						end
					end
					3'd3: begin
						scl_n = 1'b0;
						done  = 1'b1;
						ok    = 1'b1;
					end
					default: begin
						scl_n = 1'b0;
						done  = 1'b1;
					end
				endcase
			end
			i2cbm_pkg::CMD_RECV: begin
				unique case (ph_n)
					3'd0: begin
						sda_n = 1'b1;
						sh_n  = 8'd0;
						ph_n  = 3'd1;
					end
					3'd1: begin
						scl_n = 1'b1;
						sh_n  = {sh_n[6:0], sda_in};
						ph_n  = 3'd2;
					end
					default: begin
						scl_n  = 1'b0;
						bits_n = bits_n + 4'd1;
						if (bits_n >= i2cbm_pkg::BITS_PER_BYTE) begin
							rx_n = sh_n;
							done = 1'b1;
						end else begin
							ph_n = 3'd1;
						end
					end
				endcase
			end
			i2cbm_pkg::CMD_SACK: begin
				unique case (ph_n)
					3'd0: begin
						sda_n = sh_n[0];
						ph_n  = 3'd1;
					end
					3'd1: begin
						scl_n = 1'b1;
						ph_n  = 3'd2;
					end
					default: begin
						scl_n = 1'b0;
						done  = 1'b1;
					end
				endcase
			end
			i2cbm_pkg::CMD_STOP: begin
				unique case (ph_n)
					3'd0: begin
						scl_n = 1'b0;
						ph_n  = 3'd1;
					end
					3'd1: begin
						sda_n = 1'b0;
						ph_n  = 3'd2;
					end
					3'd2: begin
						scl_n = 1'b1;
						ph_n  = 3'd3;
					end
					default: begin
						sda_n = 1'b1;
						done  = 1'b1;
					end
				endcase
			end
			default: begin
				act_n = i2cbm_pkg::CMD_IDLE;
			end
		endcase
		if (done) begin
			act_n = i2cbm_pkg::CMD_IDLE;
			ph_n  = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= i2cbm_pkg::CMD_IDLE;
			ph_q   <= 3'd0;
			sh_q   <= 8'd0;
			bits_q <= 4'd0;
			poll_q <= 10'd0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			rx_q   <= 8'd0;
		end else if (step) begin
			act_q  <= act_n;
			ph_q   <= ph_n;
			sh_q   <= sh_n;
			bits_q <= bits_n;
			poll_q <= poll_n;
			scl_q  <= scl_n;
			sda_q  <= sda_n;
			rx_q   <= rx_n;
		end
	end

	always_comb begin
		res.scl_level = scl_n;
		res.sda_level = sda_n;
		res.busy_res  = (act_n != i2cbm_pkg::CMD_IDLE);
		res.done_res  = done;
		res.ok_flag   = ok;
		res.rx_byte   = rx_n;
	end

endmodule

// ----- sv/i2cbm_obuf.sv -----
module i2cbm_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  i2cbm_pkg::res_t res,
	input  logic            take,
	output logic            full,
	output i2cbm_pkg::res_t held
);

	logic            full_q;
	i2cbm_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (load) begin
			full_q <= 1'b1;
		end else if (take) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign full = full_q;
	assign held = res_q;

endmodule

// ----- sv/i2c_bit_master.sv -----
// channel   dir  bits  content
// s_*       in   13    one bus tick: command, byte, ack level, sampled SDA
// m_*       out  13    pin levels and status after that tick
// ack_*     in   10    acknowledge poll limit, written with ack_timeout_we
//
// One tick per clock cycle while the output is not stalled; the result of a
// tick sits in the output register in the cycle after the tick beat is taken.
// A new tick is taken whenever the output register is empty or being read.
// Reset releases both pins, clears the command state and sets the limit to 1000.
// A stalled result holds the bus state; no tick is taken meanwhile.
`include "assert_macros.svh"

module i2c_bit_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,           // cmd[2:0] tx_byte[10:3] ack_level[11] sda_in[12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,           // scl[0] sda[1] busy[2] done[3] ok[4] rx_byte[12:5]
	input  logic        ack_timeout_we,
	input  logic [9:0]  ack_timeout_wdata
);

	logic [9:0]      ack_timeout_q;
	logic            step;
	i2cbm_pkg::res_t res, held;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= i2cbm_pkg::ACK_TIMEOUT_RST;
		end else if (ack_timeout_we) begin
			ack_timeout_q <= ack_timeout_wdata;
		end
	end

	assign s_tready = !m_tvalid || m_tready;
	assign step     = s_tvalid && s_tready;

	i2cbm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cmd         (s_tdata[2:0]),
		.tx_byte     (s_tdata[10:3]),
		.ack_level   (s_tdata[11]),
		.sda_in      (s_tdata[12]),
		.ack_timeout (ack_timeout_q),
		.res         (res)
	);

	i2cbm_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step),
		.res    (res),
		.take   (m_tready),
		.full   (m_tvalid),
		.held   (held)
	);

	assign m_tdata = {3'd0, held.rx_byte, held.ok_flag, held.done_res, held.busy_res,
		held.sda_level, held.scl_level};

	`ASSERT_NOW(a_no_take_when_stalled, m_tvalid && !m_tready, !s_tready)
	`ASSERT_NOW(a_done_not_busy, m_tvalid, !(m_tdata[3] && m_tdata[2]))
	`ASSERT_NOW(a_ok_with_done, m_tvalid && m_tdata[4], m_tdata[3])
	`ASSERT_NEXT(a_step_fills, step, m_tvalid)

endmodule
